>>> sv/stkn_pkg.sv
// Shared constants and helpers for the source tokenizer: character codes,
// token kind codes, the keyword table and the character class functions.
// No dependencies.
package stkn_pkg;

  // Default widths of the position and line counters
  localparam int DEF_POS_BITS  = 24;
  localparam int DEF_LINE_BITS = 20;

  // Longest keyword; identifiers are matched through a prefix this long
  localparam int KW_MAX_LEN = 8;
  localparam int KW_COUNT   = 19;

  // Depth of the token group queue between scanner and output stage
  localparam int QDEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Token kinds
  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_NUMBER  = 6'd1;
  localparam logic [5:0] K_STRING  = 6'd2;
  localparam logic [5:0] K_PLUS    = 6'd3;
  localparam logic [5:0] K_MINUS   = 6'd4;
  localparam logic [5:0] K_STAR    = 6'd5;
  localparam logic [5:0] K_SLASH   = 6'd6;
  localparam logic [5:0] K_PCT     = 6'd7;
  localparam logic [5:0] K_EQEQ    = 6'd8;
  localparam logic [5:0] K_NE      = 6'd9;
  localparam logic [5:0] K_LT      = 6'd10;
  localparam logic [5:0] K_LE      = 6'd11;
  localparam logic [5:0] K_GT      = 6'd12;
  localparam logic [5:0] K_GE      = 6'd13;
  localparam logic [5:0] K_LPAR    = 6'd14;
  localparam logic [5:0] K_RPAR    = 6'd15;
  localparam logic [5:0] K_LBRACE  = 6'd16;
  localparam logic [5:0] K_RBRACE  = 6'd17;
  localparam logic [5:0] K_COMMA   = 6'd18;
  localparam logic [5:0] K_DOT     = 6'd19;
  localparam logic [5:0] K_SEMI    = 6'd20;
  localparam logic [5:0] K_ASSIGN  = 6'd21;
  localparam logic [5:0] K_KW_BASE = 6'd22;
  localparam logic [5:0] K_END     = 6'd41;
  localparam logic [5:0] K_INVALID = 6'd42;

  // Keywords packed first character in the low byte, in kind order
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0064_6e61,  // and
    64'h0000_0000_0000_726f,  // or
    64'h0000_0000_0074_6f6e,  // not
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6e65_6874,  // then
    64'h0000_0000_6573_6c65,  // else
    64'h0000_6669_6573_6c65,  // elseif
    64'h0000_0000_0064_6e65,  // end
    64'h6e6f_6974_636e_7566,  // function
    64'h0000_006c_6163_6f6c,  // local
    64'h0000_0065_6c69_6877,  // while
    64'h0000_0000_0072_6f66,  // for
    64'h0000_0000_0000_6e69,  // in
    64'h0000_0000_0000_6f64,  // do
    64'h0000_6e72_7574_6572,  // return
    64'h0000_006b_6165_7262,  // break
    64'h0000_0000_006c_696e,  // nil
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736c_6166   // false
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd3, 4'd2, 4'd4, 4'd4, 4'd6, 4'd3, 4'd8, 4'd5,
    4'd5, 4'd3, 4'd2, 4'd2, 4'd6, 4'd5, 4'd3, 4'd4, 4'd5
  };

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
  endfunction

  // Map a finished word to its keyword kind, or to identifier
  function automatic logic [5:0] kw_kind(logic [63:0] prefix, logic [3:0] len);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((len == KW_LEN[k]) && (prefix == KW_TEXT[k])) begin
        kind = K_KW_BASE + 6'(k);
      end
    end
    return kind;
  endfunction

endpackage

>>> sv/stkn_fifo.sv
// Short queue of token groups between the scanner and the output stage.
// Depends on stkn_pkg for the queue depth.
module stkn_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         nonempty
);
  import stkn_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  logic [W-1:0] mem [QDEPTH];
  logic [AW:0]  wr_ptr;
  logic [AW:0]  rd_ptr;

  assign full     = (wr_ptr ^ rd_ptr) == {1'b1, {AW{1'b0}}};
  assign nonempty = wr_ptr != rd_ptr;
  assign rd_data  = mem[rd_ptr[AW-1:0]];

  // Store an incoming group
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
  end

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

>>> sv/stkn_front.sv
// Scanner: takes one source byte per beat, updates the scan state and
// builds the group of up to three token records that the byte causes.
// Depends on stkn_pkg for character codes, kinds and keyword lookup.
module stkn_front #(
  parameter  int POS_BITS  = 24,
  parameter  int LINE_BITS = 20,
  localparam int REC_W     = 6 + LINE_BITS + 2 * POS_BITS,
  localparam int GRP_W     = 2 + 3 * REC_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       source_byte,
  input  logic             end_of_source,
  output logic             grp_valid,
  output logic [GRP_W-1:0] grp
);
  import stkn_pkg::*;

  typedef struct packed {
    logic [5:0]           kind;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  stop;
  } rec_t;

  typedef struct packed {
    logic [1:0]     cnt;
    rec_t [2:0]     recs;
  } grp_t;

  // Scan modes
  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_NUMBER     = 4'd2;
  localparam logic [3:0] M_STRING     = 4'd3;
  localparam logic [3:0] M_STR_ESC    = 4'd4;
  localparam logic [3:0] M_COMMENT    = 4'd5;
  localparam logic [3:0] M_PEND_MINUS = 4'd6;
  localparam logic [3:0] M_PEND_EQ    = 4'd7;
  localparam logic [3:0] M_PEND_LT    = 4'd8;
  localparam logic [3:0] M_PEND_GT    = 4'd9;
  localparam logic [3:0] M_PEND_BANG  = 4'd10;
  localparam logic [3:0] M_STOPPED    = 4'd11;

  localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // Append a record unless the group is already full
  function automatic grp_t add_rec(grp_t g, logic [5:0] kind, logic [LINE_BITS-1:0] line,
                                   logic [POS_BITS-1:0] start, logic [POS_BITS-1:0] stop);
    grp_t r;
    r = g;
    if (g.cnt != 2'd3) begin
      r.recs[g.cnt] = '{kind: kind, line: line, start: start, stop: stop};
      r.cnt = g.cnt + 2'd1;
    end
    return r;
  endfunction

  // Kind of a pending operator that closes without a following '='
  function automatic logic [5:0] pend_single(logic [3:0] m);
    logic [5:0] k;
    case (m)
      M_PEND_MINUS: k = K_MINUS;
      M_PEND_EQ:    k = K_ASSIGN;
      M_PEND_LT:    k = K_LT;
      M_PEND_GT:    k = K_GT;
      default:      k = K_INVALID;
    endcase
    return k;
  endfunction

  // Kind of a pending operator joined with '='
  function automatic logic [5:0] pend_pair(logic [3:0] m);
    logic [5:0] k;
    case (m)
      M_PEND_EQ: k = K_EQEQ;
      M_PEND_LT: k = K_LE;
      M_PEND_GT: k = K_GE;
      default:   k = K_NE;
    endcase
    return k;
  endfunction

  logic [3:0]           mode;
  logic [POS_BITS-1:0]  pos;
  logic [LINE_BITS-1:0] line;
  logic [POS_BITS-1:0]  tstart;
  logic [63:0]          prefix;
  logic [3:0]           wlen;

  logic [3:0]           mode_next;
  logic [POS_BITS-1:0]  pos_next;
  logic [LINE_BITS-1:0] line_next;
  logic [POS_BITS-1:0]  tstart_next;
  logic [63:0]          prefix_next;
  logic [3:0]           wlen_next;

  logic [POS_BITS-1:0]  pos1;
  logic                 handled;
  grp_t                 g;

  // Classify the byte against the current mode and collect the tokens
  always_comb begin
    pos1        = (pos == POS_MAX) ? pos : pos + POS_BITS'(1);
    mode_next   = mode;
    pos_next    = pos1;
    line_next   = line;
    tstart_next = tstart;
    prefix_next = prefix;
    wlen_next   = wlen;
    handled     = 1'b1;
    g           = '0;

    case (mode)
      M_IDLE: begin
        handled = 1'b0;
      end
      M_IDENT: begin
        if (is_word_char(source_byte)) begin
          if (wlen < 4'(KW_MAX_LEN)) begin
            prefix_next = prefix | (64'(source_byte) << {wlen[2:0], 3'b000});
          end
          if (wlen <= 4'(KW_MAX_LEN)) begin
            wlen_next = wlen + 4'd1;
          end
        end else begin
          g = add_rec(g, kw_kind(prefix, wlen), line, tstart, pos);
          mode_next = M_IDLE;
          handled   = 1'b0;
        end
      end
      M_NUMBER: begin
        if (!(is_digit(source_byte) || (source_byte == CH_DOT))) begin
          g = add_rec(g, K_NUMBER, line, tstart, pos);
          mode_next = M_IDLE;
          handled   = 1'b0;
        end
      end
      M_STRING: begin
        if (source_byte == CH_QUOTE) begin
          g = add_rec(g, K_STRING, line, tstart, pos1);
          mode_next = M_IDLE;
        end else if (source_byte == CH_BSLASH) begin
          mode_next = M_STR_ESC;
        end else if (source_byte == CH_NUL) begin
          // unterminated string, the zero byte stops the scan below
          g = add_rec(g, K_STRING, line, tstart, pos);
          mode_next = M_IDLE;
          handled   = 1'b0;
        end
      end
      M_STR_ESC: begin
        mode_next = M_STRING;
      end
      M_COMMENT: begin
        if ((source_byte == CH_NL) || (source_byte == CH_NUL)) begin
          mode_next = M_IDLE;
          handled   = 1'b0;
        end
      end
      M_PEND_MINUS: begin
        if (source_byte == CH_MINUS) begin
          mode_next = M_COMMENT;
        end else begin
          g = add_rec(g, K_MINUS, line, tstart, pos);
          mode_next = M_IDLE;
          handled   = 1'b0;
        end
      end
      M_PEND_EQ, M_PEND_LT, M_PEND_GT, M_PEND_BANG: begin
        if (source_byte == CH_EQ) begin
          g = add_rec(g, pend_pair(mode), line, tstart, pos1);
          mode_next = M_IDLE;
        end else begin
          g = add_rec(g, pend_single(mode), line, tstart, pos);
          mode_next = M_IDLE;
          handled   = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Start a new token from this byte
    if (!handled) begin
      tstart_next = pos;
      case (source_byte)
        CH_SP, CH_CR, CH_TAB: begin
        end
        CH_NL: begin
          if (line_next != LINE_MAX) begin
            line_next = line_next + LINE_BITS'(1);
          end
        end
        CH_NUL: begin
          g = add_rec(g, K_END, line_next, pos, pos);
          mode_next = M_STOPPED;
        end
        CH_QUOTE:  mode_next = M_STRING;
        CH_MINUS:  mode_next = M_PEND_MINUS;
        CH_EQ:     mode_next = M_PEND_EQ;
        CH_LT:     mode_next = M_PEND_LT;
        CH_GT:     mode_next = M_PEND_GT;
        CH_BANG:   mode_next = M_PEND_BANG;
        CH_PLUS:   g = add_rec(g, K_PLUS, line_next, pos, pos1);
        CH_STAR:   g = add_rec(g, K_STAR, line_next, pos, pos1);
        CH_SLASH:  g = add_rec(g, K_SLASH, line_next, pos, pos1);
        CH_PCT:    g = add_rec(g, K_PCT, line_next, pos, pos1);
        CH_LPAR:   g = add_rec(g, K_LPAR, line_next, pos, pos1);
        CH_RPAR:   g = add_rec(g, K_RPAR, line_next, pos, pos1);
        CH_LBRACE: g = add_rec(g, K_LBRACE, line_next, pos, pos1);
        CH_RBRACE: g = add_rec(g, K_RBRACE, line_next, pos, pos1);
        CH_COMMA:  g = add_rec(g, K_COMMA, line_next, pos, pos1);
        CH_DOT:    g = add_rec(g, K_DOT, line_next, pos, pos1);
        CH_SEMI:   g = add_rec(g, K_SEMI, line_next, pos, pos1);
        default: begin
          if (is_digit(source_byte)) begin
            mode_next = M_NUMBER;
          end else if (is_alpha(source_byte) || (source_byte == CH_USCORE)) begin
            mode_next   = M_IDENT;
            prefix_next = 64'(source_byte);
            wlen_next   = 4'd1;
          end else begin
            g = add_rec(g, K_INVALID, line_next, pos, pos1);
          end
        end
      endcase
    end

    // Close the source: flush the open token, add the end token if not yet stopped, reset
    if (end_of_source) begin
      case (mode_next)
        M_IDENT: begin
          g = add_rec(g, kw_kind(prefix_next, wlen_next), line_next, tstart_next, pos1);
        end
        M_NUMBER: begin
          g = add_rec(g, K_NUMBER, line_next, tstart_next, pos1);
        end
        M_STRING, M_STR_ESC: begin
          g = add_rec(g, K_STRING, line_next, tstart_next, pos1);
        end
        M_PEND_MINUS, M_PEND_EQ, M_PEND_LT, M_PEND_GT, M_PEND_BANG: begin
          g = add_rec(g, pend_single(mode_next), line_next, tstart_next, pos1);
        end
        default: begin
        end
      endcase
      if (mode_next != M_STOPPED) begin
        g = add_rec(g, K_END, line_next, pos1, pos1);
      end
      mode_next   = M_IDLE;
      pos_next    = '0;
      line_next   = LINE_ONE;
      tstart_next = '0;
      prefix_next = '0;
      wlen_next   = '0;
    end
  end

  assign grp       = g;
  assign grp_valid = accept && (g.cnt != 2'd0);

  // Hold the scan state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      line   <= LINE_ONE;
      tstart <= '0;
      prefix <= '0;
      wlen   <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      line   <= line_next;
      tstart <= tstart_next;
      prefix <= prefix_next;
      wlen   <= wlen_next;
    end
  end

endmodule

>>> sv/stkn_back.sv
// Output stage: takes token groups from the queue, sends their records out
// one per beat through an output register and computes token lengths.
// No package dependencies.
module stkn_back #(
  parameter  int POS_BITS  = 24,
  parameter  int LINE_BITS = 20,
  localparam int REC_W     = 6 + LINE_BITS + 2 * POS_BITS,
  localparam int GRP_W     = 2 + 3 * REC_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 grp_valid,
  input  logic [GRP_W-1:0]     grp,
  output logic                 grp_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [5:0]           token_kind,
  output logic [LINE_BITS-1:0] token_line,
  output logic [POS_BITS-1:0]  token_start,
  output logic [POS_BITS-1:0]  token_length,
  output logic                 last_of_run
);

  typedef struct packed {
    logic [5:0]           kind;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  stop;
  } rec_t;

  typedef struct packed {
    logic [1:0]     cnt;
    rec_t [2:0]     recs;
  } grp_t;

  grp_t                head;
  rec_t                cur;
  logic [1:0]          idx;
  logic                out_valid;
  logic                load;
  logic                at_last;
  logic [POS_BITS-1:0] len;

  assign head    = grp;
  assign cur     = head.recs[idx];
  assign at_last = (idx + 2'd1) == head.cnt;
  assign load    = grp_valid && (!out_valid || pop);
  assign grp_pop = load && at_last;
  assign empty   = !out_valid;
  assign len     = (cur.stop >= cur.start) ? cur.stop - cur.start : '0;

  // Step through the records of the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_last ? 2'd0 : idx + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= cur.kind;
      token_line   <= cur.line;
      token_start  <= cur.start;
      token_length <= len;
      last_of_run  <= at_last;
    end
  end

endmodule

>>> sv/source_tokenizer_top.sv
// Source tokenizer top level. A byte's tokens reach the result ports through
// the group queue and then the output register. One byte is accepted per
// cycle while the four-group queue has room; the output stage sends one
// token per cycle while the consumer keeps popping, so the k tokens of a
// byte leave one after another. Synchronous active-high rst clears the scan
// state (line count one, offsets zero), the queue and the output valid flag.
module source_tokenizer_top #(
  parameter int POS_BITS  = stkn_pkg::DEF_POS_BITS,
  parameter int LINE_BITS = stkn_pkg::DEF_LINE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           source_byte,
  input  logic                 end_of_source,
  output logic                 empty,
  input  logic                 pop,
  output logic [5:0]           token_kind,
  output logic [LINE_BITS-1:0] token_line,
  output logic [POS_BITS-1:0]  token_start,
  output logic [POS_BITS-1:0]  token_length,
  output logic                 last_of_run
);

  localparam int REC_W = 6 + LINE_BITS + 2 * POS_BITS;
  localparam int GRP_W = 2 + 3 * REC_W;

  logic             accept;
  logic             wr_en;
  logic [GRP_W-1:0] wr_grp;
  logic             q_nonempty;
  logic [GRP_W-1:0] q_grp;
  logic             q_pop;

  assign accept = push && !full;

  // Scan bytes into token groups
  stkn_front #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .source_byte   (source_byte),
    .end_of_source (end_of_source),
    .grp_valid     (wr_en),
    .grp           (wr_grp)
  );

  // Buffer groups between scanner and output stage
  stkn_fifo #(
    .W (GRP_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_grp),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_grp),
    .nonempty (q_nonempty)
  );

  // Send tokens one per beat
  stkn_back #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .grp_valid    (q_nonempty),
    .grp          (q_grp),
    .grp_pop      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

endmodule
